/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

/* rtl/pds_pkg.sv */
// Shared types and constants of the particle depth sorter.
package pds_pkg;
    localparam int CAPACITY = 64;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // One stored particle with its sort key.
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [63:0] color;
        logic [31:0] size;
    } pds_item_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COEF_X = 2'd0;
    localparam logic [1:0] REG_COEF_Y = 2'd1;
    localparam logic [1:0] REG_COEF_Z = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM, ST_DRAIN} pds_state_t;

    // Control from the sequencer to each cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } pds_ctl_t;
endpackage

/* rtl/pds_cell.sv */
// One cell of the sorting chain: holds one particle, inserts or shifts.
module pds_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  pds_pkg::pds_ctl_t  ctl,
    input  pds_pkg::pds_item_t new_item,
    input  pds_pkg::pds_item_t prev_item,
    input  logic               prev_valid,
    input  logic               prev_takes,
    input  logic               clear,
    output pds_pkg::pds_item_t item,
    output logic               valid,
    output logic               takes
);
    import pds_pkg::*;

    pds_item_t item_reg;
    logic      valid_reg;

    // The new particle goes behind all keys that are greater or equal.
    assign takes = !valid_reg || (new_item.key > item_reg.key);
    assign item  = item_reg;
    assign valid = valid_reg;

    // Insertion: the first taking cell stores the new item, later ones shift.
    always_ff @(posedge clk)
    begin
        if (ctl.insert && takes)
        begin
            if (prev_takes)
                item_reg <= prev_item;
            else
                item_reg <= new_item;
        end
        else if (ctl.shift)
        begin
            item_reg <= prev_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (clear)
            valid_reg <= 1'b0;
        else if (ctl.insert && takes)
            valid_reg <= prev_takes ? prev_valid : 1'b1;
        else if (ctl.shift)
            valid_reg <= prev_valid;
    end
endmodule

/* rtl/pds_depth.sv */
// Two-stage depth key unit: three products, then the saturated sum.
module pds_depth
(
    input  logic        clk,
    input  logic        mul_en,
    input  logic        sum_en,
    input  logic [31:0] coef_x,
    input  logic [31:0] coef_y,
    input  logic [31:0] coef_z,
    input  logic [31:0] offset,
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] z,
    output logic [63:0] key
);
    logic signed [63:0] px_reg, py_reg, pz_reg;
    logic [63:0]        key_reg;
    logic signed [66:0] total;
    logic signed [66:0] max_v, min_v;

    // Each Q16.16 product is exact in Q32.32.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            px_reg <= $signed(coef_x) * $signed(x);
            py_reg <= $signed(coef_y) * $signed(y);
            pz_reg <= $signed(coef_z) * $signed(z);
        end
    end

    // Saturate the exact sum and flip the sign bit for an unsigned order.
    always_comb
    begin
        max_v = {4'b0000, {63{1'b1}}};
        min_v = {4'b1111, {63{1'b0}}};
        total = 67'(px_reg) + 67'(py_reg) + 67'(pz_reg)
              + {{19{offset[31]}}, offset, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            if (total > max_v)
                key_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
            else if (total < min_v)
                key_reg <= 64'd0;
            else
                key_reg <= {~total[63], total[62:0]};
        end
    end

    assign key = key_reg;
endmodule

/* rtl/particle_depth_sorter_top.sv */
// Top level of the particle depth sorter.
// Usage: write the four depth-row registers over the APB port while idle.
// Pulse start with one particle on the payload ports; busy is high from the
// accepting edge at least until the particle is inserted.
// The three 32x32 products are taken at the accepting edge, the saturated
// sum in the next cycle and the insertion into the chain of cells in the
// one after. The chain keeps the stored particles sorted farthest first,
// equal depths in arrival order.
// A particle carrying batch_end is inserted, then the chain drains one
// particle per cycle from its head: out_valid marks each result for exactly
// one cycle and run_end marks the last. busy stays high until the last
// particle has left the chain; the last result is shown in the first cycle
// in which busy is low.
// The receiver cannot stall: results are presented once. Beyond CAPACITY
// particles further ones are dropped.
// Reset clears the registers to their defaults and empties the chain.
module particle_depth_sorter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic [15:0] alpha,
    input  logic [31:0] particle_size,
    input  logic        batch_end,
    output logic        out_valid,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [15:0] out_red,
    output logic [15:0] out_green,
    output logic [15:0] out_blue,
    output logic [15:0] out_alpha,
    output logic [31:0] out_size,
    output logic        run_end
);
    import pds_pkg::*;

    logic [31:0] coef_x_reg, coef_y_reg, coef_z_reg, offset_reg;
    pds_state_t  state_reg, state_next;
    pds_item_t   in_reg;
    logic        end_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [63:0] key;
    logic        accept, mul_en, sum_en, do_ins, do_shift, clear;
    pds_ctl_t    ctl;
    pds_item_t   new_item;
    pds_item_t   items [CAPACITY];
    logic        valids [CAPACITY];
    logic        takes [CAPACITY];
    pds_item_t   head;
    logic        out_valid_reg, run_end_reg;
    pds_item_t   out_reg;

    assign pready = 1'b1;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= 32'd0;
            coef_y_reg <= 32'd0;
            coef_z_reg <= 32'h0001_0000;
            offset_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_COEF_X: coef_x_reg <= pwdata;
                REG_COEF_Y: coef_y_reg <= pwdata;
                REG_COEF_Z: coef_z_reg <= pwdata;
                REG_OFFSET: offset_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_COEF_X: prdata = coef_x_reg;
            REG_COEF_Y: prdata = coef_y_reg;
            REG_COEF_Z: prdata = coef_z_reg;
            REG_OFFSET: prdata = offset_reg;
            default:    prdata = 32'd0;
        endcase
    end

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg.key   <= 64'd0;
            in_reg.x     <= pos_x;
            in_reg.y     <= pos_y;
            in_reg.z     <= pos_z;
            in_reg.color <= {red, green, blue, alpha};
            in_reg.size  <= particle_size;
            end_reg      <= batch_end;
        end
    end

    // The products are taken straight from the request at the accepting edge.
    pds_depth u_depth
    (
        .clk    (clk),
        .mul_en (mul_en),
        .sum_en (sum_en),
        .coef_x (coef_x_reg),
        .coef_y (coef_y_reg),
        .coef_z (coef_z_reg),
        .offset (offset_reg),
        .x      (pos_x),
        .y      (pos_y),
        .z      (pos_z),
        .key    (key)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:
            begin
                if (!end_reg)
                    state_next = ST_IDLE;
                else if (fill_next == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: if (left_reg == CNT_W'(1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy     = (state_reg != ST_IDLE);
        mul_en   = accept;
        sum_en   = (state_reg == ST_MUL);
        do_ins   = (state_reg == ST_SUM) && (fill_reg != CNT_W'(CAPACITY));
        do_shift = (state_reg == ST_DRAIN);
        clear    = (state_reg == ST_DRAIN) && (left_reg == CNT_W'(1));
        fill_next = do_ins ? fill_reg + CNT_W'(1) : fill_reg;
        left_next = left_reg;
        if (state_reg == ST_SUM)
            left_next = fill_next;
        else if (do_shift)
            left_next = left_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            if (state_reg == ST_SUM && end_reg)
                fill_reg <= '0;
            else
                fill_reg <= fill_next;
        end
    end

    // The chain of cells; the head leaves first while draining.
    always_comb
    begin
        new_item     = in_reg;
        new_item.key = key;
        ctl.insert   = do_ins;
        ctl.shift    = do_shift;
        head         = items[0];
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pds_item_t prev_item;
        logic      prev_valid, prev_takes;
        pds_ctl_t  cctl;
        always_comb
        begin
            cctl = ctl;
            if (i == 0)
            begin
                prev_item  = new_item;
                prev_valid = 1'b0;
                prev_takes = 1'b0;
            end
            else
            begin
                prev_item  = items[(i == 0) ? 0 : i - 1];
                prev_valid = valids[(i == 0) ? 0 : i - 1];
                prev_takes = takes[(i == 0) ? 0 : i - 1];
            end
            // Draining moves towards the head, so shift reads the next cell.
            if (do_shift)
            begin
                if (i == CAPACITY - 1)
                begin
                    prev_item  = new_item;
                    prev_valid = 1'b0;
                end
                else
                begin
                    prev_item  = items[(i == CAPACITY - 1) ? i : i + 1];
                    prev_valid = valids[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
        pds_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cctl),
            .new_item   (new_item),
            .prev_item  (prev_item),
            .prev_valid (prev_valid),
            .prev_takes (prev_takes),
            .clear      (clear),
            .item       (items[i]),
            .valid      (valids[i]),
            .takes      (takes[i])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= do_shift;
            run_end_reg   <= clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_shift)
            out_reg <= head;
    end

    assign out_valid = out_valid_reg;
    assign run_end   = run_end_reg;
    assign out_x     = out_reg.x;
    assign out_y     = out_reg.y;
    assign out_z     = out_reg.z;
    assign out_red   = out_reg.color[63:48];
    assign out_green = out_reg.color[47:32];
    assign out_blue  = out_reg.color[31:16];
    assign out_alpha = out_reg.color[15:0];
    assign out_size  = out_reg.size;
endmodule

/* rtl/pds_checker.sv */
// Port-level checks of the particle depth sorter, bound to the top level.
`include "assert_macros.svh"
module pds_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic out_valid,
    input logic run_end,
    input logic pready
);
    `CHK_IMPL(a_end_valid, clk, rst_n, run_end, out_valid)
    `CHK_NEXT(a_busy_after_req, clk, rst_n, start && !busy, busy)
    `CHK_NEXT(a_quiet_after_end, clk, rst_n, run_end, !out_valid)
    `CHK_IMPL(a_ready, clk, rst_n, 1'b1, pready)
endmodule

bind particle_depth_sorter_top pds_checker u_pds_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .run_end   (run_end),
    .pready    (pready)
);

/* tb/sv/tb_top.sv */
// Self-checking particle depth sorter bench: directed table, saturation, full store, random.
module tb_top;
    import pds_pkg::*;

    // Expected particle as it leaves the sorter.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
        logic [31:0] sz;
        logic        last;
    } particle_t;

    // One row of the directed table; chk_x holds a typed-in x of the first result.
    typedef struct {
        particle_t p;
        bit        has_chk;
        logic [31:0] chk_x;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [31:0] particle_size;
    logic        batch_end;
    logic        out_valid;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [31:0] out_size;
    logic        run_end;

    // Predictor state: depth-row registers and the sorted store.
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic signed [31:0] coef_z;
    logic signed [31:0] offset_q;
    particle_t   sorted_parts[$];
    logic [63:0] sorted_keys[$];

    particle_t   emitted_q[$];
    logic [31:0] pinned_x[$];
    bit          first_of_run = 1'b1;
    int          error_count;
    dir_row_t    dir_rows[$];

    particle_depth_sorter_top u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #50000000;
        $display("FAIL particle_depth_sorter_top");
        $finish;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Saturated Q32.32 depth with the sign bit flipped, so it orders as unsigned.
    function automatic logic [63:0] depth_key(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z);
        logic signed [66:0] sum;
        logic signed [63:0] d;
        sum = $signed(coef_x) * $signed(x);
        sum = sum + $signed(coef_y) * $signed(y);
        sum = sum + $signed(coef_z) * $signed(z);
        sum = sum + $signed(offset_q) * 67'sd65536;
        if (sum > 67'sh0_7FFF_FFFF_FFFF_FFFF)
            d = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (sum < -67'sh0_8000_0000_0000_0000)
            d = 64'h8000_0000_0000_0000;
        else
            d = sum[63:0];
        return d ^ 64'h8000_0000_0000_0000;
    endfunction

    // Insert one accepted particle; on batch end move the whole run to the expected queue.
    task automatic sort_particle(input particle_t p);
        logic [63:0] k;
        int pos;
        logic last;
        last = p.last;
        k = depth_key(p.x, p.y, p.z);
        if (sorted_parts.size() < CAPACITY)
        begin
            pos = 0;
            while (pos < sorted_keys.size() && sorted_keys[pos] >= k)
                pos++;
            p.last = 1'b0;
            sorted_parts.insert(pos, p);
            sorted_keys.insert(pos, k);
        end
        if (last)
        begin
            foreach (sorted_parts[i])
            begin
                sorted_parts[i].last = (i == sorted_parts.size() - 1);
                emitted_q.push_back(sorted_parts[i]);
            end
            sorted_parts.delete();
            sorted_keys.delete();
        end
    endtask

    // APB write: setup cycle then access cycle until pready, then psel is dropped and the bus idles.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COEF_X: coef_x = val;
            REG_COEF_Y: coef_y = val;
            REG_COEF_Z: coef_z = val;
            default:    offset_q = val;
        endcase
        @(posedge clk);
    endtask

    // Wait for all results, then let the block settle before touching registers.
    task automatic drain_all();
        while (emitted_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Send one request; the batch_end bit travels in p.last.
    task automatic send_particle(input particle_t p, input int gap);
        repeat (gap) @(posedge clk);
        start         <= 1'b1;
        pos_x         <= p.x;
        pos_y         <= p.y;
        pos_z         <= p.z;
        red           <= p.r;
        green         <= p.g;
        blue          <= p.b;
        alpha         <= p.a;
        particle_size <= p.sz;
        batch_end     <= p.last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sort_particle(p);
        start <= 1'b0;
        // The block is busy in the next cycle anyway.
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 4) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rand_particle(input bit last, input bit narrow);
        particle_t p;
        p.x    = narrow ? 32'($signed($urandom_range(0, 8)) - 4) << 16 : rand_word();
        p.y    = rand_word();
        p.z    = narrow ? 32'($signed($urandom_range(0, 8)) - 4) << 16 : rand_word();
        p.r    = $urandom;
        p.g    = $urandom;
        p.b    = $urandom;
        p.a    = $urandom;
        p.sz   = $urandom;
        p.last = last;
        return p;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Compare every strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        particle_t want;
        if (rst_n && out_valid)
        begin
            if (emitted_q.size() == 0)
            begin
                $display("unexpected result x=%h at %0t", out_x, $realtime);
                error_count++;
            end
            else
            begin
                want = emitted_q.pop_front();
                // A typed-in x applies to the first result of a run.
                if (first_of_run && pinned_x.size() != 0)
                begin
                    if (out_x !== pinned_x[0])
                        report_mismatch("pinned x", out_x, pinned_x[0]);
                    void'(pinned_x.pop_front());
                end
                first_of_run = want.last;
                if (out_x !== want.x)     report_mismatch("out_x", out_x, want.x);
                if (out_y !== want.y)     report_mismatch("out_y", out_y, want.y);
                if (out_z !== want.z)     report_mismatch("out_z", out_z, want.z);
                if (out_red !== want.r)   report_mismatch("out_red", out_red, want.r);
                if (out_green !== want.g) report_mismatch("out_green", out_green, want.g);
                if (out_blue !== want.b)  report_mismatch("out_blue", out_blue, want.b);
                if (out_alpha !== want.a) report_mismatch("out_alpha", out_alpha, want.a);
                if (out_size !== want.sz) report_mismatch("out_size", out_size, want.sz);
                if (run_end !== want.last) report_mismatch("run_end", run_end, want.last);
            end
        end
    end

    // Main sequence.
    initial
    begin
        particle_t p;
        int n_items;
        int batch_len;
        bit narrow;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        red = '0;
        green = '0;
        blue = '0;
        alpha = '0;
        particle_size = '0;
        batch_end = 1'b0;
        error_count = 0;
        coef_x = 32'sd0;
        coef_y = 32'sd0;
        coef_z = 32'sd65536;
        offset_q = 32'sd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset coefficients sort by z; the largest z leaves first.
        dir_rows.push_back('{'{32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 16'h0000,
                               16'hFFFF, 16'h0000, 16'hFFFF, 32'h8000_0000, 1'b0},
                             1'b1, 32'h0000_0003});
        dir_rows.push_back('{'{32'h0000_0002, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                               16'h0000, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 1'b0}, 1'b0, 0});
        dir_rows.push_back('{'{32'h0000_0003, 32'h0000_0000, 32'h7FFF_FFFF, 16'h1234,
                               16'h5678, 16'h9ABC, 16'hDEF0, 32'h0000_0000, 1'b0}, 1'b0, 0});
        // Equal depths keep arrival order.
        dir_rows.push_back('{'{32'h0000_0004, 32'h1, 32'h0001_0000, 16'h1, 16'h2, 16'h3,
                               16'h4, 32'h5, 1'b0}, 1'b0, 0});
        dir_rows.push_back('{'{32'hFFFF_FFFF, 32'h2, 32'h0001_0000, 16'h6, 16'h7, 16'h8,
                               16'h9, 32'hA, 1'b1}, 1'b0, 0});
        // A lone particle with batch end is a run of one.
        dir_rows.push_back('{'{32'h0000_00AA, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                               32'h0, 1'b1}, 1'b1, 32'h0000_00AA});
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].has_chk)
                pinned_x.push_back(dir_rows[i].chk_x);
            send_particle(dir_rows[i].p, rand_gap());
        end
        drain_all();

        // Extreme coefficients saturate the key both ways.
        write_reg(REG_COEF_X, 32'h7FFF_FFFF);
        write_reg(REG_COEF_Y, 32'h7FFF_FFFF);
        write_reg(REG_COEF_Z, 32'h8000_0000);
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_particle(rand_particle(i == 7, 1'b0), rand_gap());
        drain_all();

        // Store full: 66 particles, the last two dropped, batch still emitted.
        write_reg(REG_COEF_X, 32'h0000_0000);
        write_reg(REG_COEF_Y, 32'h0000_0000);
        write_reg(REG_COEF_Z, 32'h0001_0000);
        write_reg(REG_OFFSET, 32'h8000_0000);
        for (int i = 0; i < CAPACITY + 2; i++)
            send_particle(rand_particle(i == CAPACITY + 1, 1'b1), (i < 20) ? 0 : rand_gap());
        drain_all();

        // Random batches, with coefficients changed between phases.
        n_items = 0;
        while (n_items < 270)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain_all();
                write_reg(REG_COEF_X, rand_word());
                write_reg(REG_COEF_Y, rand_word());
                write_reg(REG_COEF_Z, rand_word());
                write_reg(REG_OFFSET, rand_word());
            end
            batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 8);
            narrow = $urandom_range(0, 1);
            for (int i = 0; i < batch_len; i++)
            begin
                p = rand_particle(i == batch_len - 1, narrow);
                send_particle(p, rand_gap());
                n_items++;
            end
            // Now and then the sender holds off until the whole run has come back.
            if ($urandom_range(0, 4) == 0)
                drain_all();
        end

        drain_all();
        repeat (80) @(posedge clk);
        if (error_count == 0 && emitted_q.size() == 0)
            $display("PASS particle_depth_sorter_top");
        else
            $display("FAIL particle_depth_sorter_top");
        $finish;
    end
endmodule
